[src/rpt_pkg.sv]
package rpt_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    localparam int SRC_W = 16;
    localparam int SEQ_W = 24;
    localparam int VERDICT_W = 2;
    localparam int ENTRY_W = SRC_W + SEQ_W;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    localparam logic [VERDICT_W-1:0] VERDICT_ACCEPT = 2'd0;
    localparam logic [VERDICT_W-1:0] VERDICT_REPLAY = 2'd1;
    localparam logic [VERDICT_W-1:0] VERDICT_FULL   = 2'd2;

    typedef struct packed {
        logic [SRC_W-1:0] source;
        logic [SEQ_W-1:0] seq_num;
    } entry_t;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } state_t;

endpackage

[src/rpt_if.sv]
interface rpt_req_if;
    logic                      valid;
    logic                      ready;
    logic [rpt_pkg::SRC_W-1:0] source_address;
    logic [rpt_pkg::SEQ_W-1:0] sequence_number;

    modport source (output valid, output source_address, output sequence_number, input ready);
    modport sink (input valid, input source_address, input sequence_number, output ready);
endinterface

interface rpt_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [rpt_pkg::VERDICT_W-1:0] verdict;

    modport source (output valid, output verdict, input ready);
    modport sink (input valid, input verdict, output ready);
endinterface

[src/replay_protection_table_core.sv]
// Each request walks the table from entry 0; a source match at an entry ends the walk there,
// otherwise all TABLE_ENTRIES entries are walked. A new request is taken only in the idle
// state, so no new request is taken while one is still being walked; the
// table is walked one entry per cycle through one read port and one shared comparator.
// A verdict waiting in the output register does not block the next request.
// Reset: asynchronous, active low; clears all valid marks and the control state.
module replay_protection_table_core (
    input  logic              clk,
    input  logic              rst_n,
    rpt_req_if.sink           req,
    rpt_rsp_if.source         rsp
);

    rpt_pkg::state_t                   state_reg, state_next;
    logic [rpt_pkg::SRC_W-1:0]         src_reg, src_next;
    logic [rpt_pkg::SEQ_W-1:0]         seq_reg, seq_next;
    logic [rpt_pkg::IDX_W-1:0]         scan_idx_reg, scan_idx_next;
    logic                              issue_done_reg, issue_done_next;
    logic [rpt_pkg::IDX_W-1:0]         cmp_idx_reg, cmp_idx_next;
    logic                              cmp_vld_reg, cmp_vld_next;
    logic [rpt_pkg::IDX_W-1:0]         slot_reg, slot_next;
    logic                              have_slot_reg, have_slot_next;
    logic [rpt_pkg::VERDICT_W-1:0]     result_reg, result_next;
    logic [rpt_pkg::VERDICT_W-1:0]     verdict_reg, verdict_next;
    logic                              out_valid_reg, out_valid_next;
    logic [rpt_pkg::TABLE_ENTRIES-1:0] valid_reg, valid_next;

    rpt_pkg::entry_t                   mem [rpt_pkg::TABLE_ENTRIES];
    rpt_pkg::entry_t                   rd_data_reg;
    logic                              mem_we;
    logic [rpt_pkg::IDX_W-1:0]         mem_waddr;
    rpt_pkg::entry_t                   mem_wdata;

    logic                              entry_live;
    logic                              src_hit;
    logic                              req_fire;

    assign req.ready   = (state_reg == rpt_pkg::S_IDLE);
    assign req_fire    = req.valid && req.ready;
    assign rsp.valid   = out_valid_reg;
    assign rsp.verdict = verdict_reg;

    assign entry_live = valid_reg[cmp_idx_reg];
    assign src_hit    = entry_live && (rd_data_reg.source == src_reg);

    always_comb
    begin
        state_next      = state_reg;
        src_next        = src_reg;
        seq_next        = seq_reg;
        scan_idx_next   = scan_idx_reg;
        issue_done_next = issue_done_reg;
        cmp_idx_next    = cmp_idx_reg;
        cmp_vld_next    = 1'b0;
        slot_next       = slot_reg;
        have_slot_next  = have_slot_reg;
        result_next     = result_reg;
        verdict_next    = verdict_reg;
        out_valid_next  = out_valid_reg;
        valid_next      = valid_reg;
        mem_we          = 1'b0;
        mem_waddr       = cmp_idx_reg;
        mem_wdata       = '{source: src_reg, seq_num: seq_reg};

        if (rsp.valid && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            rpt_pkg::S_IDLE:
            begin
                if (req_fire)
                begin
                    src_next        = req.source_address;
                    seq_next        = req.sequence_number;
                    scan_idx_next   = '0;
                    issue_done_next = 1'b0;
                    have_slot_next  = 1'b0;
                    state_next      = rpt_pkg::S_SCAN;
                end
            end
            rpt_pkg::S_SCAN:
            begin
                // read issue for the next entry, compare runs in the cycle after the issue
                if (!issue_done_reg)
                begin
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = scan_idx_reg;
                    if (scan_idx_reg == rpt_pkg::LAST_IDX)
                    begin
                        issue_done_next = 1'b1;
                    end
                    else
                    begin
                        scan_idx_next = scan_idx_reg + 1'b1;
                    end
                end

                if (cmp_vld_reg)
                begin
                    if (!entry_live && !have_slot_reg)
                    begin
                        have_slot_next = 1'b1;
                        slot_next      = cmp_idx_reg;
                    end

                    priority if (src_hit)
                    begin
                        cmp_vld_next = 1'b0;
                        state_next   = rpt_pkg::S_DONE;
                        if (seq_reg <= rd_data_reg.seq_num)
                        begin
                            result_next = rpt_pkg::VERDICT_REPLAY;
                        end
                        else
                        begin
                            mem_we      = 1'b1;
                            mem_waddr   = cmp_idx_reg;
                            result_next = rpt_pkg::VERDICT_ACCEPT;
                        end
                    end
                    else if (cmp_idx_reg == rpt_pkg::LAST_IDX)
                    begin
                        state_next = rpt_pkg::S_DONE;
                        if (have_slot_reg || !entry_live)
                        begin
                            mem_we      = 1'b1;
                            mem_waddr   = have_slot_reg ? slot_reg : cmp_idx_reg;
                            valid_next[mem_waddr] = 1'b1;
                            result_next = rpt_pkg::VERDICT_ACCEPT;
                        end
                        else
                        begin
                            result_next = rpt_pkg::VERDICT_FULL;
                        end
                    end
                    else
                    begin
                        state_next = rpt_pkg::S_SCAN;
                    end
                end
            end
            rpt_pkg::S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    verdict_next   = result_reg;
                    out_valid_next = 1'b1;
                    state_next     = rpt_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = rpt_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= rpt_pkg::S_IDLE;
            cmp_vld_reg    <= 1'b0;
            issue_done_reg <= 1'b0;
            have_slot_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
            valid_reg      <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            cmp_vld_reg    <= cmp_vld_next;
            issue_done_reg <= issue_done_next;
            have_slot_reg  <= have_slot_next;
            out_valid_reg  <= out_valid_next;
            valid_reg      <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        src_reg      <= src_next;
        seq_reg      <= seq_next;
        scan_idx_reg <= scan_idx_next;
        cmp_idx_reg  <= cmp_idx_next;
        slot_reg     <= slot_next;
        result_reg   <= result_next;
        verdict_reg  <= verdict_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[scan_idx_reg];
    end

    a_verdict_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (rsp.verdict == rpt_pkg::VERDICT_ACCEPT ||
                       rsp.verdict == rpt_pkg::VERDICT_REPLAY ||
                       rsp.verdict == rpt_pkg::VERDICT_FULL))
        else $error("illegal verdict code");

    a_start_scan: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> (state_reg == rpt_pkg::S_SCAN && !cmp_vld_reg))
        else $error("request did not start a fresh scan");

    a_valid_grows: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) >= $countones($past(valid_reg)))
        else $error("valid marks lost");

    a_full_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rpt_pkg::S_DONE && result_reg == rpt_pkg::VERDICT_FULL)
            |-> (&valid_reg))
        else $error("table full verdict with a free entry");

endmodule

[tb/replay_protection_table_core_tb.sv]
module replay_protection_table_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     CLK_PERIOD      = 10;
    localparam int     RANDOM_REQUESTS = 1800;
    localparam int     PHASES          = 4;
    localparam longint CYCLE_LIMIT     = 1_000_000;
    localparam logic [rpt_pkg::SEQ_W-1:0] SEQ_MAX = '1;

    // Tracks the table contents and the verdicts still owed by the block.
    class replay_verdict_board;
        logic [rpt_pkg::VERDICT_W-1:0] pending_verdicts[$];
        bit                            known_valid[rpt_pkg::TABLE_ENTRIES];
        logic [rpt_pkg::SRC_W-1:0]     known_source[rpt_pkg::TABLE_ENTRIES];
        logic [rpt_pkg::SEQ_W-1:0]     known_sequence[rpt_pkg::TABLE_ENTRIES];
        int                            error_count;

        function new();
            foreach (known_valid[i])
            begin
                known_valid[i] = 1'b0;
            end
            error_count = 0;
        endfunction

        function logic [rpt_pkg::VERDICT_W-1:0] predict_verdict(
            logic [rpt_pkg::SRC_W-1:0] src, logic [rpt_pkg::SEQ_W-1:0] seq);
            int slot;
            slot = -1;
            for (int i = 0; i < rpt_pkg::TABLE_ENTRIES; i++)
            begin
                if (!known_valid[i])
                begin
                    if (slot < 0)
                        slot = i;
                end
                else if (known_source[i] == src)
                begin
                    // equal number counts as a replay
                    if (seq <= known_sequence[i])
                        return rpt_pkg::VERDICT_REPLAY;
                    known_sequence[i] = seq;
                    return rpt_pkg::VERDICT_ACCEPT;
                end
            end
            if (slot < 0)
                return rpt_pkg::VERDICT_FULL;
            known_valid[slot]    = 1'b1;
            known_source[slot]   = src;
            known_sequence[slot] = seq;
            return rpt_pkg::VERDICT_ACCEPT;
        endfunction

        function void note_request(logic [rpt_pkg::SRC_W-1:0] src,
                                   logic [rpt_pkg::SEQ_W-1:0] seq);
            pending_verdicts.push_back(predict_verdict(src, seq));
        endfunction

        task report(string what);
            if (error_count < 200)
                $display("[%0t] verdict check failed: %s", $realtime, what);
            error_count++;
        endtask

        task check_verdict(logic [rpt_pkg::VERDICT_W-1:0] got);
            logic [rpt_pkg::VERDICT_W-1:0] want;
            if (pending_verdicts.size() == 0)
            begin
                report($sformatf("verdict %0d with no request outstanding", got));
            end
            else
            begin
                want = pending_verdicts.pop_front();
                if (got !== want)
                    report($sformatf("got %0d, want %0d", got, want));
            end
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;
    int   send_idle_pct;
    int   stall_pct;
    replay_verdict_board board;

    rpt_req_if req_ch ();
    rpt_rsp_if rsp_ch ();

    replay_protection_table_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Called right after a rising edge; returns at the edge that takes the request.
    task automatic send_request(logic [rpt_pkg::SRC_W-1:0] src,
                                logic [rpt_pkg::SEQ_W-1:0] seq);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid           <= 1'b1;
        req_ch.source_address  <= src;
        req_ch.sequence_number <= seq;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        board.note_request(src, seq);
    endtask

    // Mostly known sources with numbers around the stored one, some unknown sources.
    function automatic void pick_request(output logic [rpt_pkg::SRC_W-1:0] src,
                                         output logic [rpt_pkg::SEQ_W-1:0] seq);
        int                        idx;
        int                        roll;
        logic [rpt_pkg::SEQ_W-1:0] last;
        idx  = $urandom_range(rpt_pkg::TABLE_ENTRIES - 1);
        roll = $urandom_range(99);
        src  = rpt_pkg::SRC_W'($urandom);
        seq  = rpt_pkg::SEQ_W'($urandom);
        if (roll < 15 || !board.known_valid[idx])
            return;
        src  = board.known_source[idx];
        last = board.known_sequence[idx];
        if (roll < 65)
        begin
            if (last <= SEQ_MAX - 4096)
                seq = rpt_pkg::SEQ_W'(last + $urandom_range(1, 4096));
        end
        else if (roll < 78)
            seq = last;
        else if (roll < 90 && last != 0)
            seq = rpt_pkg::SEQ_W'($urandom_range(0, int'(last) - 1));
    endfunction

    task automatic wait_for_verdicts();
        while (board.pending_verdicts.size() != 0)
            @(posedge clk);
    endtask

    // Response side: check on handshake, then draw the next ready.
    initial
    begin
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_ch.valid && rsp_ch.ready)
                board.check_verdict(rsp_ch.verdict);
            rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    initial
    begin
        longint cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("replay_protection_table_core: mismatch");
        $finish;
    end

    initial
    begin
        logic [rpt_pkg::SRC_W-1:0] src;
        logic [rpt_pkg::SEQ_W-1:0] seq;
        bit                        hit;

        board                  = new();
        send_idle_pct          = 0;
        stall_pct              = 0;
        rst_n                  <= 1'b0;
        req_ch.valid           <= 1'b0;
        req_ch.source_address  <= '0;
        req_ch.sequence_number <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: insert, equal and lower numbers, field extremes
        send_request(16'h0000, 24'h000000);
        send_request(16'h0000, 24'h000000);
        send_request(16'h0000, 24'hFFFFFF);
        send_request(16'h0000, 24'h000001);
        send_request(16'hFFFF, 24'hFFFFFF);
        send_request(16'hFFFF, 24'hFFFFFF);
        send_request(16'hFFFF, 24'h000000);
        // fill the rest of the table
        while (!board.known_valid[rpt_pkg::TABLE_ENTRIES - 1])
            send_request(rpt_pkg::SRC_W'($urandom_range(1, 16'hFFFE)),
                         rpt_pkg::SEQ_W'($urandom));
        // unknown source into a full table
        do
        begin
            src = rpt_pkg::SRC_W'($urandom);
            hit = 1'b0;
            for (int i = 0; i < rpt_pkg::TABLE_ENTRIES; i++)
                hit |= (board.known_source[i] == src);
        end
        while (hit);
        send_request(src, 24'hFFFFFF);
        send_request(src, 24'h000000);
        // known sources still work with the table full
        send_request(board.known_source[5], board.known_sequence[5] + 1'b1);
        send_request(board.known_source[rpt_pkg::TABLE_ENTRIES - 1],
                     board.known_sequence[rpt_pkg::TABLE_ENTRIES - 1]);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 59; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 59; end
                default: begin send_idle_pct = 9; stall_pct = 9; end
            endcase
            repeat (RANDOM_REQUESTS / PHASES)
            begin
                pick_request(src, seq);
                send_request(src, seq);
            end
            // hold off new requests until the block has answered everything
            req_ch.valid <= 1'b0;
            wait_for_verdicts();
        end

        repeat (rpt_pkg::TABLE_ENTRIES + 8) @(posedge clk);
        if (board.error_count == 0)
            $display("replay_protection_table_core: match");
        else
            $display("replay_protection_table_core: mismatch");
        $finish;
    end

endmodule
